>>> rtl/core/pltally_pkg.sv
// Shared types and codes for the pileup line base tally block.
// No dependencies; imported by every module of the block except pltally_ram.
package pltally_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [5:0]  sample_slot;
      logic [31:0] site_position;
      logic [2:0]  ref_code;
      logic [12:0] count_a;
      logic [12:0] count_c;
      logic [12:0] count_g;
      logic [12:0] count_t;
      logic [12:0] count_n;
      logic [12:0] count_del;
      logic [3:0]  error_code;
      logic        line_last;
   } rsp_type;

   typedef struct packed {
      logic        quality_present;
      logic        ancestral_present;
      logic        strict_bases;
      logic [6:0]  min_quality;
      logic [6:0]  quality_offset;
      logic        filter_enable;
      logic [63:0] sample_mask;
   } cfg_type;

   localparam logic [2:0] CSR_QUALITY_PRESENT   = 3'd0;
   localparam logic [2:0] CSR_ANCESTRAL_PRESENT = 3'd1;
   localparam logic [2:0] CSR_STRICT_BASES      = 3'd2;
   localparam logic [2:0] CSR_MIN_QUALITY       = 3'd3;
   localparam logic [2:0] CSR_QUALITY_OFFSET    = 3'd4;
   localparam logic [2:0] CSR_FILTER_ENABLE     = 3'd5;
   localparam logic [2:0] CSR_SAMPLE_MASK       = 3'd6;

   localparam logic [3:0] ERR_OK          = 4'd0;
   localparam logic [3:0] ERR_EMPTY       = 4'd1;
   localparam logic [3:0] ERR_ZERO_POS    = 4'd2;
   localparam logic [3:0] ERR_BAD_REF     = 4'd3;
   localparam logic [3:0] ERR_BAD_INDEL   = 4'd4;
   localparam logic [3:0] ERR_TRUNC_MARK  = 4'd5;
   localparam logic [3:0] ERR_COV_MISM    = 4'd6;
   localparam logic [3:0] ERR_QUAL_MISM   = 4'd7;
   localparam logic [3:0] ERR_BAD_ALLELE  = 4'd8;
   localparam logic [3:0] ERR_BAD_ANC     = 4'd9;
   localparam logic [3:0] ERR_SAMPLE_CNT  = 4'd10;
   localparam logic [3:0] ERR_BAD_CHAR    = 4'd11;

endpackage

>>> rtl/core/pltally_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pltally_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/pltally_outq.sv
// Two-word result queue between the parser and the result channel.
// Depends on pltally_pkg.
module pltally_outq
   import pltally_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_word,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   rsp_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign full      = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_word;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("result pushed into full queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

endmodule

>>> rtl/core/pltally_parser.sv
// Byte-serial pileup line parser and tally unit; drives the base store RAM.
// Depends on pltally_pkg.
module pltally_parser
   import pltally_pkg::*;
#(
   parameter int MAX_DEPTH   = 4096,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  req_type                      req_word,
   input  cfg_type                      cfg,
   output logic                         emit_valid,
   output rsp_type                      emit_word,
   output logic                         mem_we,
   output logic [$clog2(MAX_DEPTH)-1:0] mem_waddr,
   output logic [2:0]                   mem_wdata,
   output logic [$clog2(MAX_DEPTH)-1:0] mem_raddr,
   input  logic [2:0]                   mem_rdata
);

   localparam int AW = $clog2(MAX_DEPTH);
   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam logic [DW-1:0] DEPTH_LIM = DW'(MAX_DEPTH);
   localparam logic [12:0]   INDEL_LIMIT = 13'd8191;

   localparam logic [7:0] CH_TAB = 8'h09, CH_NL = 8'h0a, CH_CARET = 8'h5e;
   localparam logic [7:0] CH_DOLLAR = 8'h24, CH_PLUS = 8'h2b, CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_LT = 8'h3c, CH_GT = 8'h3e, CH_STAR = 8'h2a;
   localparam logic [7:0] CH_HASH = 8'h23, CH_DOT = 8'h2e, CH_COMMA = 8'h2c;

   localparam logic [4:0] P_START = 5'd0, P_CHROM = 5'd1, P_POS0 = 5'd2;
   localparam logic [4:0] P_POS = 5'd3, P_REF = 5'd4, P_SEP = 5'd5;
   localparam logic [4:0] P_COV0 = 5'd6, P_COV = 5'd7, P_BASES = 5'd8;
   localparam logic [4:0] P_CARET = 5'd9, P_INDEL0 = 5'd10, P_INDELN = 5'd11;
   localparam logic [4:0] P_INDELC = 5'd12, P_QUAL = 5'd13, P_ANC = 5'd14;
   localparam logic [4:0] P_DELIM = 5'd15, P_SKCOV = 5'd16, P_SKBASES = 5'd17;
   localparam logic [4:0] P_SKQUAL = 5'd18, P_SKANC = 5'd19;

   localparam logic [2:0] B_N = 3'd4, B_DEL = 3'd5, B_IGN = 3'd6, B_BAD = 3'd7;

   function automatic logic is_printable(input logic [7:0] b);
      return (b >= 8'h21) && (b <= 8'h7e);
   endfunction

   function automatic logic is_numeral(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   // 0..4 for ACGTN, 5 otherwise
   function automatic logic [2:0] nuc_code(input logic [7:0] b);
      logic [7:0] u;
      u = (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
      case (u)
         8'h41:   return 3'd0;
         8'h43:   return 3'd1;
         8'h47:   return 3'd2;
         8'h54:   return 3'd3;
         8'h4e:   return 3'd4;
         default: return 3'd5;
      endcase
   endfunction

   function automatic logic [2:0] base_code(input logic [7:0] b);
      logic [2:0] n;
      n = nuc_code(b);
      if (n < 3'd5) return n;
      if (b == CH_STAR || b == CH_HASH) return B_DEL;
      if (b == CH_LT || b == CH_GT) return B_IGN;
      return B_BAD;
   endfunction

   logic [4:0]    phase_ff, phase_in;
   logic [31:0]   acc_ff, acc_in, pos_ff, pos_in;
   logic [2:0]    refb_ff, refb_in;
   logic [DW-1:0] cov_ff, cov_in, wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [12:0]   indel_ff, indel_in;
   logic [12:0]   tally_ff [6];
   logic [12:0]   tally_in [6];
   logic [6:0]    src_ff, src_in, dst_ff, dst_in, exp_ff, exp_in;
   logic          known_ff, known_in, discard_ff, discard_in;
   logic          pending_ff, pending_in, kept_ff, kept_in, bad_ff, bad_in;

   logic       do_fail, do_bases, do_indelc, do_after, do_delim, do_end;
   logic       do_lb, ended, normal;
   logic [3:0] fcode;
   logic [7:0] b;
   logic [35:0] numv;
   logic [2:0] bcode, ncode;
   logic [7:0] qdiff;

   always_comb begin
      phase_in = phase_ff; acc_in = acc_ff; pos_in = pos_ff; refb_in = refb_ff;
      cov_in = cov_ff; wptr_in = wptr_ff; rptr_in = rptr_ff; indel_in = indel_ff;
      for (int i = 0; i < 6; i++) tally_in[i] = tally_ff[i];
      src_in = src_ff; dst_in = dst_ff; exp_in = exp_ff; known_in = known_ff;
      discard_in = discard_ff; pending_in = pending_ff; kept_in = kept_ff;
      bad_in = bad_ff;
      do_fail = 1'b0; do_bases = 1'b0; do_indelc = 1'b0; do_after = 1'b0;
      do_delim = 1'b0; do_end = 1'b0; do_lb = 1'b0; ended = 1'b0; normal = 1'b0;
      fcode = ERR_OK;
      emit_valid = 1'b0;
      emit_word = '0;
      mem_we = 1'b0;

      b = req_word.stream_end ? CH_NL : req_word.data_byte;
      numv = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {32'd0, b[3:0]};
      bcode = (b == CH_DOT || b == CH_COMMA) ? refb_ff : base_code(b);
      ncode = nuc_code(b);
      qdiff = b - {1'b0, cfg.quality_offset};
      mem_wdata = bcode;
      mem_waddr = wptr_ff[AW-1:0];

      if (go) begin
         if (discard_ff) begin
            if (b == CH_NL) do_lb = 1'b1;
         end else if (req_word.stream_end) begin
            case (phase_ff)
               P_START: ;
               P_CARET: begin do_fail = 1'b1; fcode = ERR_TRUNC_MARK; end
               P_INDELC: begin do_fail = 1'b1; fcode = ERR_BAD_INDEL; end
               P_INDELN: begin
                  if (acc_ff != 32'd0) begin
                     do_fail = 1'b1; fcode = ERR_BAD_INDEL;
                  end else begin
                     phase_in = P_BASES; do_bases = 1'b1;
                  end
               end
               P_REF: begin
                  if (cfg.strict_bases) begin
                     do_fail = 1'b1; fcode = ERR_BAD_REF;
                  end else begin
                     refb_in = B_N; do_end = 1'b1;
                  end
               end
               P_ANC: begin
                  if (cfg.strict_bases) begin
                     do_fail = 1'b1; fcode = ERR_BAD_ANC;
                  end else begin
                     do_delim = 1'b1; ended = 1'b1;
                  end
               end
               default: normal = 1'b1;
            endcase
         end else begin
            normal = 1'b1;
         end
      end

      if (normal) begin
         case (phase_ff)
            P_START: begin
               if (!is_printable(b)) begin do_fail = 1'b1; fcode = ERR_EMPTY; end
               else phase_in = P_CHROM;
            end
            P_CHROM: begin
               if (!is_printable(b)) begin
                  if (b != CH_TAB) begin do_fail = 1'b1; fcode = ERR_BAD_CHAR; end
                  else phase_in = P_POS0;
               end
            end
            P_POS0: begin
               if (!is_numeral(b)) begin do_fail = 1'b1; fcode = ERR_BAD_CHAR; end
               else begin acc_in = {28'd0, b[3:0]}; phase_in = P_POS; end
            end
            P_POS: begin
               if (is_numeral(b)) begin
                  if (numv[35:32] != 4'd0) begin do_fail = 1'b1; fcode = ERR_BAD_CHAR; end
                  else acc_in = numv[31:0];
               end else if (acc_ff == 32'd0) begin
                  do_fail = 1'b1; fcode = ERR_ZERO_POS;
               end else if (b != CH_TAB) begin
                  do_fail = 1'b1; fcode = ERR_BAD_CHAR;
               end else begin
                  pos_in = acc_ff; phase_in = P_REF;
               end
            end
            P_REF: begin
               if (ncode > 3'd4 && cfg.strict_bases) begin
                  do_fail = 1'b1; fcode = ERR_BAD_REF;
               end else begin
                  refb_in = (ncode > 3'd4) ? B_N : ncode;
                  phase_in = P_SEP;
               end
            end
            P_SEP: do_delim = 1'b1;
            P_COV0: begin
               if ((known_ff && dst_ff >= exp_ff) || dst_ff >= 7'(MAX_SAMPLES)) begin
                  do_fail = 1'b1; fcode = ERR_SAMPLE_CNT;
               end else if (!is_numeral(b)) begin
                  do_fail = 1'b1; fcode = ERR_BAD_CHAR;
               end else begin
                  acc_in = {28'd0, b[3:0]}; phase_in = P_COV;
                  if (pending_ff) begin
                     emit_valid = 1'b1;
                     emit_word = '{sample_slot: 6'(dst_ff - 7'd1),
                        site_position: pos_ff, ref_code: refb_ff,
                        count_a: tally_ff[0], count_c: tally_ff[1],
                        count_g: tally_ff[2], count_t: tally_ff[3],
                        count_n: tally_ff[4], count_del: tally_ff[5],
                        error_code: ERR_OK, line_last: 1'b0};
                     pending_in = 1'b0;
                  end
               end
            end
            P_COV: begin
               if (is_numeral(b)) begin
                  if (numv > 36'(MAX_DEPTH)) begin do_fail = 1'b1; fcode = ERR_BAD_CHAR; end
                  else acc_in = numv[31:0];
               end else if (b != CH_TAB) begin
                  do_fail = 1'b1; fcode = ERR_BAD_CHAR;
               end else begin
                  cov_in = acc_ff[DW-1:0]; wptr_in = '0; bad_in = 1'b0;
                  for (int i = 0; i < 6; i++) tally_in[i] = 13'd0;
                  phase_in = P_BASES;
               end
            end
            P_BASES: do_bases = 1'b1;
            P_CARET: phase_in = P_BASES;
            P_INDEL0: begin
               if (!is_numeral(b)) begin do_fail = 1'b1; fcode = ERR_BAD_INDEL; end
               else begin acc_in = {28'd0, b[3:0]}; phase_in = P_INDELN; end
            end
            P_INDELN: begin
               if (is_numeral(b)) begin
                  if (numv > {23'd0, INDEL_LIMIT}) begin
                     do_fail = 1'b1; fcode = ERR_BAD_CHAR;
                  end else acc_in = numv[31:0];
               end else if (acc_ff == 32'd0) begin
                  phase_in = P_BASES; do_bases = 1'b1;
               end else begin
                  indel_in = acc_ff[12:0]; phase_in = P_INDELC; do_indelc = 1'b1;
               end
            end
            P_INDELC: do_indelc = 1'b1;
            P_QUAL: begin
               if (is_printable(b)) begin
                  if (rptr_ff >= wptr_ff || rptr_ff >= DEPTH_LIM) begin
                     do_fail = 1'b1; fcode = ERR_QUAL_MISM;
                  end else if (b < {1'b0, cfg.quality_offset}) begin
                     do_fail = 1'b1; fcode = ERR_BAD_CHAR;
                  end else if (qdiff >= {1'b0, cfg.min_quality} && mem_rdata == B_BAD) begin
                     do_fail = 1'b1; fcode = ERR_BAD_ALLELE;
                  end else begin
                     if (qdiff >= {1'b0, cfg.min_quality} && mem_rdata < B_IGN)
                        tally_in[mem_rdata] = tally_ff[mem_rdata] + 13'd1;
                     rptr_in = rptr_ff + DW'(1);
                  end
               end else if (rptr_ff != wptr_ff) begin
                  do_fail = 1'b1; fcode = ERR_QUAL_MISM;
               end else do_after = 1'b1;
            end
            P_ANC: begin
               if (ncode > 3'd4 && cfg.strict_bases) begin
                  do_fail = 1'b1; fcode = ERR_BAD_ANC;
               end else phase_in = P_DELIM;
            end
            P_DELIM: begin do_delim = 1'b1; ended = 1'b1; end
            P_SKCOV: begin
               if (!is_numeral(b)) begin
                  if (b != CH_TAB) begin do_fail = 1'b1; fcode = ERR_BAD_CHAR; end
                  else phase_in = P_SKBASES;
               end
            end
            P_SKBASES: begin
               if (!is_printable(b)) begin
                  if (cfg.quality_present || cfg.ancestral_present) begin
                     if (b != CH_TAB) begin do_fail = 1'b1; fcode = ERR_BAD_CHAR; end
                     else phase_in = cfg.quality_present ? P_SKQUAL : P_SKANC;
                  end else begin
                     do_delim = 1'b1; ended = 1'b1;
                  end
               end
            end
            P_SKQUAL: begin
               if (!is_printable(b)) begin
                  if (cfg.ancestral_present) begin
                     if (b != CH_TAB) begin do_fail = 1'b1; fcode = ERR_BAD_CHAR; end
                     else phase_in = P_SKANC;
                  end else begin
                     do_delim = 1'b1; ended = 1'b1;
                  end
               end
            end
            P_SKANC: begin
               if (!is_printable(b)) begin do_delim = 1'b1; ended = 1'b1; end
            end
            default: do_lb = 1'b1;
         endcase
      end

      // indel body character
      if (do_indelc && !do_fail) begin
         if (cfg.strict_bases && base_code(b) > B_DEL) begin
            do_fail = 1'b1; fcode = ERR_BAD_INDEL;
         end else begin
            if (indel_in != 13'd0) indel_in = indel_in - 13'd1;
            if (indel_in == 13'd0) phase_in = P_BASES;
         end
      end

      // read-base column byte
      if (do_bases && !do_fail) begin
         if (is_printable(b)) begin
            if (b == CH_PLUS || b == CH_MINUS) phase_in = P_INDEL0;
            else if (b == CH_CARET) phase_in = P_CARET;
            else if (b != CH_DOLLAR) begin
               if (wptr_ff >= DEPTH_LIM) begin
                  do_fail = 1'b1; fcode = ERR_BAD_CHAR;
               end else begin
                  mem_we = 1'b1;
                  wptr_in = wptr_ff + DW'(1);
                  if (!cfg.quality_present) begin
                     if (bcode < B_IGN) tally_in[bcode] = tally_ff[bcode] + 13'd1;
                     else if (bcode == B_BAD) bad_in = 1'b1;
                  end
               end
            end
         end else if (!(wptr_ff == cov_ff || (cov_ff == '0 && wptr_ff == DW'(1)))) begin
            do_fail = 1'b1; fcode = ERR_COV_MISM;
         end else if (cfg.quality_present) begin
            if (b != CH_TAB) begin do_fail = 1'b1; fcode = ERR_BAD_CHAR; end
            else begin rptr_in = '0; phase_in = P_QUAL; end
         end else if (bad_ff) begin
            do_fail = 1'b1; fcode = ERR_BAD_ALLELE;
         end else do_after = 1'b1;
      end

      if (do_after && !do_fail) begin
         if (cfg.ancestral_present) begin
            if (b != CH_TAB) begin do_fail = 1'b1; fcode = ERR_BAD_CHAR; end
            else phase_in = P_ANC;
         end else begin
            do_delim = 1'b1; ended = 1'b1;
         end
      end

      if (do_delim && !do_fail) begin
         if (b != CH_TAB && b != CH_NL) begin
            do_fail = 1'b1; fcode = ERR_BAD_CHAR;
         end else begin
            if (ended) begin
               if (kept_in) begin
                  pending_in = 1'b1;
                  if (dst_in < 7'd127) dst_in = dst_in + 7'd1;
               end
               if (src_in < 7'd127) src_in = src_in + 7'd1;
            end
            if (b == CH_NL) do_end = 1'b1;
            else begin
               kept_in = !cfg.filter_enable ||
                  (src_in < 7'd64 && cfg.sample_mask[src_in[5:0]]);
               phase_in = kept_in ? P_COV0 : P_SKCOV;
            end
         end
      end

      if (do_end && !do_fail) begin
         if (known_in && dst_in != exp_in) begin
            do_fail = 1'b1; fcode = ERR_SAMPLE_CNT;
         end else begin
            if (dst_in != 7'd0) begin known_in = 1'b1; exp_in = dst_in; end
            if (pending_in) begin
               emit_valid = 1'b1;
               emit_word = '{sample_slot: 6'(dst_in - 7'd1),
                  site_position: pos_in, ref_code: refb_in,
                  count_a: tally_in[0], count_c: tally_in[1],
                  count_g: tally_in[2], count_t: tally_in[3],
                  count_n: tally_in[4], count_del: tally_in[5],
                  error_code: ERR_OK, line_last: 1'b1};
            end
            do_lb = 1'b1;
         end
      end

      if (do_fail) begin
         emit_valid = 1'b1;
         emit_word = '0;
         emit_word.sample_slot   = dst_in[5:0];
         emit_word.site_position = pos_in;
         emit_word.ref_code      = refb_in;
         emit_word.error_code    = fcode;
         emit_word.line_last     = 1'b1;
         pending_in = 1'b0;
         if (b == CH_NL) do_lb = 1'b1;
         else discard_in = 1'b1;
      end

      if (do_lb || (go && req_word.stream_end)) begin
         phase_in = P_START; pos_in = '0; refb_in = B_N; acc_in = '0;
         src_in = '0; dst_in = '0; pending_in = 1'b0; kept_in = 1'b0;
         discard_in = 1'b0;
      end
      if (go && req_word.stream_end) begin
         known_in = 1'b0; exp_in = '0;
      end

      // the store is read every cycle at the next read pointer, so the entry
      // for the next quality byte is already on mem_rdata
      mem_raddr = rptr_in[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_START; acc_ff <= '0; pos_ff <= '0; refb_ff <= B_N;
         cov_ff <= '0; wptr_ff <= '0; rptr_ff <= '0; indel_ff <= '0;
         for (int i = 0; i < 6; i++) tally_ff[i] <= '0;
         src_ff <= '0; dst_ff <= '0; exp_ff <= '0; known_ff <= 1'b0;
         discard_ff <= 1'b0; pending_ff <= 1'b0; kept_ff <= 1'b0; bad_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; acc_ff <= acc_in; pos_ff <= pos_in; refb_ff <= refb_in;
         cov_ff <= cov_in; wptr_ff <= wptr_in; rptr_ff <= rptr_in; indel_ff <= indel_in;
         for (int i = 0; i < 6; i++) tally_ff[i] <= tally_in[i];
         src_ff <= src_in; dst_ff <= dst_in; exp_ff <= exp_in; known_ff <= known_in;
         discard_ff <= discard_in; pending_ff <= pending_in; kept_ff <= kept_in;
         bad_ff <= bad_in;
      end
   end

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> wptr_ff < DEPTH_LIM) else $error("base store write past depth");
   a_read_behind: assert property (@(posedge clock) disable iff (reset)
      phase_ff == P_QUAL |-> rptr_ff <= wptr_ff) else $error("read pointer ahead");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      emit_valid && emit_word.error_code != ERR_OK |-> emit_word.line_last)
      else $error("error word not marked last");
   a_idle_no_emit: assert property (@(posedge clock) disable iff (reset)
      !go |-> !emit_valid && !mem_we) else $error("activity without accepted byte");

endmodule

>>> rtl/core/pileup_line_base_tally.sv
// Pileup line base tally: byte-serial pileup text checker and per-sample counter.
// Latency: a result word is queued at the edge that accepts the byte causing it
//   and shows on rsp_valid the next cycle.
// Throughput: one byte per cycle while not stalled; bases go into the store and each
//   quality byte reads its entry from the registered-read store RAM, prefetched at the read pointer.
// Input stalls only while both slots of the two-word result queue are full.
// Reset (synchronous): parser at line start, queue empty, registers at defaults;
//   the base store is not cleared, every entry read was written for that sample.
module pileup_line_base_tally
   import pltally_pkg::*;
#(
   parameter int MAX_DEPTH   = 4096,
   parameter int MAX_SAMPLES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int AW = $clog2(MAX_DEPTH);

   cfg_type cfg_ff;
   logic    go;
   logic    q_full;
   logic    emit_valid;
   rsp_type emit_word;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [2:0]    mem_wdata, mem_rdata;

   // config registers; the user must write them only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quality_present   <= 1'b1;
         cfg_ff.ancestral_present <= 1'b0;
         cfg_ff.strict_bases      <= 1'b1;
         cfg_ff.min_quality       <= 7'd0;
         cfg_ff.quality_offset    <= 7'd33;
         cfg_ff.filter_enable     <= 1'b0;
         cfg_ff.sample_mask       <= '1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_QUALITY_PRESENT:   cfg_ff.quality_present   <= csr_wdata[0];
            CSR_ANCESTRAL_PRESENT: cfg_ff.ancestral_present <= csr_wdata[0];
            CSR_STRICT_BASES:      cfg_ff.strict_bases      <= csr_wdata[0];
            CSR_MIN_QUALITY:       cfg_ff.min_quality       <= csr_wdata[6:0];
            CSR_QUALITY_OFFSET:    cfg_ff.quality_offset    <= csr_wdata[6:0];
            CSR_FILTER_ENABLE:     cfg_ff.filter_enable     <= csr_wdata[0];
            CSR_SAMPLE_MASK:       cfg_ff.sample_mask       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stall comes from a registered queue count, never from rsp_stall directly
   assign req_stall = q_full;
   assign go        = req_valid && !req_stall;

   pltally_parser #(
      .MAX_DEPTH  (MAX_DEPTH),
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .req_word  (req_data),
      .cfg       (cfg_ff),
      .emit_valid(emit_valid),
      .emit_word (emit_word),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // base store: one code per read base of the current sample
   pltally_ram #(
      .WIDTH(3),
      .DEPTH(MAX_DEPTH)
   ) u_store (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   pltally_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (emit_valid),
      .push_word(emit_word),
      .full     (q_full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
